>>> rtl/stc_pkg.sv
// types, keyword tables and kind codes shared by the token classifier
package stc_pkg;

    localparam int KW_COUNT = 14;

    typedef logic [4:0] kind_t;
    typedef logic [3:0] pos_t;

    // keyword kinds are their index in the table, 0..13
    localparam kind_t KIND_INTEGER      = 5'd14;
    localparam kind_t KIND_LITERAL      = 5'd15;
    localparam kind_t KIND_IDENTIFIER   = 5'd16;
    localparam kind_t KIND_UNRECOGNIZED = 5'd17;

    localparam pos_t POS_SAT = 4'd9;

    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // keyword text, right aligned: the first byte sits highest
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'("="), 64'("!="), 64'("<"), 64'("<="), 64'(">="), 64'(">"),
        64'("AND"), 64'("OR"), 64'("NOT"), 64'("IN"),
        64'("SELECT"), 64'("DISTINCT"), 64'("FROM"), 64'("WHERE")
    };

    localparam pos_t KW_LEN [KW_COUNT] = '{
        4'd1, 4'd2, 4'd1, 4'd2, 4'd2, 4'd1, 4'd3,
        4'd2, 4'd3, 4'd2, 4'd6, 4'd8, 4'd4, 4'd5
    };

    // one byte request handed from the input register to the scanner
    typedef struct packed {
        logic       take;
        logic [7:0] char_code;
        logic       is_last;
    } scan_req_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

endpackage

>>> rtl/stc_scan.sv
// running token state and the per-byte classification logic
module stc_scan
(
    input  logic              clk,
    input  logic              rst_n,
    input  stc_pkg::scan_req_t req,
    output stc_pkg::kind_t    kind
);

    logic [stc_pkg::KW_COUNT-1:0] alive_reg, alive_next;
    stc_pkg::pos_t                pos_reg, pos_next;
    logic                         digits_reg, digits_next;
    logic                         ident_reg, ident_next;
    logic                         opened_reg, opened_next;
    logic                         nolb_reg, nolb_next;

    logic [stc_pkg::KW_COUNT-1:0] kw_hit;
    logic [stc_pkg::KW_COUNT-1:0] kw_done;
    stc_pkg::pos_t                kw_off [stc_pkg::KW_COUNT];
    logic                         first;
    logic                         is_quote;
    logic                         word_ch;

    // keyword byte compare at the current position
    always_comb
    begin
        for (int k = 0; k < stc_pkg::KW_COUNT; k++)
        begin
            kw_off[k]  = stc_pkg::KW_LEN[k] - 4'd1 - pos_reg;
            kw_hit[k]  = (pos_reg < stc_pkg::KW_LEN[k]) &&
                         (stc_pkg::KW_TEXT[k][{kw_off[k][2:0], 3'b000} +: 8] == req.char_code);
            kw_done[k] = alive_reg[k] && kw_hit[k] && (pos_reg == stc_pkg::KW_LEN[k] - 4'd1);
        end
    end

    always_comb
    begin
        first       = (pos_reg == '0);
        is_quote    = (req.char_code == stc_pkg::CH_QUOTE);
        word_ch     = stc_pkg::is_letter(req.char_code) || stc_pkg::is_digit(req.char_code) ||
                      (req.char_code == stc_pkg::CH_UNDER);
        alive_next  = alive_reg & kw_hit;
        digits_next = digits_reg & stc_pkg::is_digit(req.char_code);
        ident_next  = first ? stc_pkg::is_letter(req.char_code) : (ident_reg & word_ch);
        opened_next = first ? is_quote : opened_reg;
        nolb_next   = nolb_reg & (req.char_code != stc_pkg::CH_LF) &
                      (req.char_code != stc_pkg::CH_CR);
        pos_next    = (pos_reg < stc_pkg::POS_SAT) ? pos_reg + 4'd1 : stc_pkg::POS_SAT;
    end

    // lowest keyword index wins, then the general rules
    always_comb
    begin
        kind = stc_pkg::KIND_UNRECOGNIZED;
        if (digits_next)
            kind = stc_pkg::KIND_INTEGER;
        else if (opened_next && is_quote && !first && nolb_next)
            kind = stc_pkg::KIND_LITERAL;
        else if (ident_next)
            kind = stc_pkg::KIND_IDENTIFIER;
        for (int k = stc_pkg::KW_COUNT - 1; k >= 0; k--)
        begin
            if (kw_done[k])
                kind = stc_pkg::kind_t'(k);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg  <= '1;
            pos_reg    <= '0;
            digits_reg <= 1'b1;
            ident_reg  <= 1'b1;
            opened_reg <= 1'b0;
            nolb_reg   <= 1'b1;
        end
        else if (req.take)
        begin
            if (req.is_last)
            begin
                alive_reg  <= '1;
                pos_reg    <= '0;
                digits_reg <= 1'b1;
                ident_reg  <= 1'b1;
                opened_reg <= 1'b0;
                nolb_reg   <= 1'b1;
            end
            else
            begin
                alive_reg  <= alive_next;
                pos_reg    <= pos_next;
                digits_reg <= digits_next;
                ident_reg  <= ident_next;
                opened_reg <= opened_next;
                nolb_reg   <= nolb_next;
            end
        end
    end

    a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= stc_pkg::POS_SAT)
        else $error("token position ran past saturation");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (req.take && req.is_last) |=> (pos_reg == '0 && alive_reg == '1))
        else $error("running state not cleared after last byte");

    a_alive_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (req.take && !req.is_last) |=> ((alive_reg & ~$past(alive_reg)) == '0))
        else $error("keyword match bit came back mid token");

endmodule

>>> rtl/sql_token_classifier.sv
// top level of the token classifier: input register, scanner, result register
//
//  channel  signals                         direction  request
//  -------  ------------------------------  ---------  ---------------------------
//  byte     byte_valid byte_stall           in         char_code, is_last
//  kind     kind_valid kind_stall           out        token_kind
//
// one byte request per cycle sustained while no last byte waits on a stalled
// kind; the last byte of a token sits in the input register, then its kind
// loads the result register
// the scanner state updates in the same cycle the byte leaves the input register
// rst_n clears the running token state and both valid flags at once
// a stalled kind only holds up last bytes; other bytes keep flowing
module sql_token_classifier
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    output logic           byte_stall,
    input  logic [7:0]     char_code,
    input  logic           is_last,
    output logic           kind_valid,
    input  logic           kind_stall,
    output logic [4:0]     token_kind
);

    // input register
    logic       in_v_reg;
    logic [7:0] char_reg;
    logic       last_reg;

    // result register
    logic            out_v_reg, out_v_next;
    stc_pkg::kind_t  kind_reg;

    logic               advance;
    logic               byte_acc;
    stc_pkg::scan_req_t req;
    stc_pkg::kind_t     kind_comb;

    // a held byte moves on unless it is a last byte facing a full, stalled result
    assign advance    = in_v_reg && (!last_reg || !out_v_reg || !kind_stall);
    assign byte_stall = in_v_reg && !advance;
    assign byte_acc   = byte_valid && !byte_stall;

    always_comb
    begin
        req.take      = advance;
        req.char_code = char_reg;
        req.is_last   = last_reg;
    end

    stc_scan u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .kind  (kind_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (byte_acc)
            in_v_reg <= 1'b1;
        else if (advance)
            in_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (byte_acc)
        begin
            char_reg <= char_code;
            last_reg <= is_last;
        end
    end

    always_comb
    begin
        out_v_next = out_v_reg;
        priority if (advance && last_reg)
            out_v_next = 1'b1;
        else if (!kind_stall)
            out_v_next = 1'b0;
        else
            out_v_next = out_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else
            out_v_reg <= out_v_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
            kind_reg <= kind_comb;
    end

    assign kind_valid = out_v_reg;
    assign token_kind = kind_reg;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> (in_v_reg && last_reg && out_v_reg))
        else $error("byte stall raised without a blocked last byte");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_reg) |-> (!out_v_reg || !kind_stall))
        else $error("pending kind overwritten");

    a_full_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_acc && in_v_reg) |-> advance)
        else $error("byte accepted into an occupied input register");

endmodule
